/* src/http_request_framer_top_defines.svh */
// Assertion macros shared by the framer RTL.
`ifndef HTTP_REQUEST_FRAMER_TOP_DEFINES_SVH
`define HTTP_REQUEST_FRAMER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define HRF_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define HRF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/hrf_pkg.sv */
package hrf_pkg;

    // Role tag of one stream byte
    typedef enum logic [2:0] {
        CLS_METHOD  = 3'd0,
        CLS_TARGET  = 3'd1,
        CLS_VERSION = 3'd2,
        CLS_NAME    = 3'd3,
        CLS_VALUE   = 3'd4,
        CLS_SEP     = 3'd5,
        CLS_BODY    = 3'd6
    } byte_class_t;

    // Sticky error codes
    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_BAD_BYTE = 3'd1,
        ERR_BARE_LF  = 3'd2,
        ERR_TOKENS   = 3'd3,
        ERR_NO_COLON = 3'd4,
        ERR_OVERFLOW = 3'd5
    } err_t;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Header name match tracker: length of the key, and the "lost" marker
    localparam logic [3:0] NAME_LEN = 4'd14;
    localparam logic [3:0] NO_MATCH = 4'd15;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CHAR_SPACE) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic byte_ok(input logic [7:0] b);
        return (b >= 8'h20 && b <= 8'h7E) || is_ws(b);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) ? (b + 8'd32) : b;
    endfunction

    // Lower-case "content-length", one character per position
    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h63; // c
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h6C; // l
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* src/http_request_framer_top.sv */
// HTTP/1.1 request framer.
// Input channel (s_valid/s_ready): one connection byte per item, with
// s_new_connection set on the first byte of a new connection, which clears
// all parser state before that byte is handled.
// Result channel (m_valid/m_ready): exactly one result item per input item:
// byte class, header end flag, parsed content length (on header end only),
// request end flag and the sticky error code.
// A byte accepted at one edge shows up on the m_ ports after that edge.
// Throughput is one byte per cycle while the receiver keeps up; the per-byte
// state update (including the multiply-by-ten of the length parser and the
// body down-counter) is combinational between the state registers and the
// result register.
// s_ready is high whenever the result register is empty or being taken, so a
// stalled receiver holds the current result and stops input after it.
// Reset (aresetn low, synchronous) empties the result register and returns
// the parser to the request line with no error and zero lengths.
// Once an error is raised, every result carries that error code with all
// other fields zero until a byte with s_new_connection arrives.
`include "http_request_framer_top_defines.svh"

module http_request_framer_top #(
    parameter int LENGTH_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_new_connection,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_byte_class,
    output logic        m_header_end,
    output logic [31:0] m_body_length,
    output logic        m_request_end,
    output logic [2:0]  m_error_code
);

    localparam int ExtBits = LENGTH_BITS + 4;

    typedef enum logic [1:0] {
        PH_REQ  = 2'd0,
        PH_HDR  = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        VS_SKIP   = 2'd0,
        VS_DIGITS = 2'd1,
        VS_DONE   = 2'd2
    } vstate_t;

    // Parser state
    phase_t                   phase_reg, phase_next, cur_phase;
    logic [1:0]               space_reg, space_next, cur_space;
    logic                     prev_cr_reg, prev_cr_next, cur_prev_cr;
    logic                     line_empty_reg, line_empty_next, cur_line_empty;
    logic                     colon_reg, colon_next, cur_colon;
    logic [3:0]               match_reg, match_next, cur_match;
    vstate_t                  vstate_reg, vstate_next, cur_vstate;
    logic [LENGTH_BITS-1:0]   acc_reg, acc_next, cur_acc;
    logic [LENGTH_BITS-1:0]   clv_reg, clv_next, cur_clv;
    logic [LENGTH_BITS-1:0]   body_rem_reg, body_rem_next, cur_body_rem;
    hrf_pkg::err_t            sticky_reg, sticky_next, cur_sticky;

    // Result register
    logic                     m_valid_reg;
    hrf_pkg::byte_class_t     cls_reg, cls_next;
    logic                     hdr_end_reg, hdr_end_next;
    logic [31:0]              blen_reg, blen_next;
    logic                     req_end_reg, req_end_next;
    hrf_pkg::err_t            err_reg, err_next;

    // Datapath helpers
    logic                     accept;
    logic [7:0]               b;
    logic                     digit;
    logic [3:0]               digit_val;
    logic [ExtBits-1:0]       acc_ext;
    logic [ExtBits-1:0]       acc_x10;
    logic                     acc_ovf;
    logic [63:0]              clv_wide;
    logic                     line_rst;
    hrf_pkg::err_t            fail_code;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign b       = s_data_byte;

    // Current state: a new connection starts from reset values
    always_comb begin
        if (s_new_connection) begin
            cur_phase      = PH_REQ;
            cur_space      = 2'd0;
            cur_prev_cr    = 1'b0;
            cur_line_empty = 1'b1;
            cur_colon      = 1'b0;
            cur_match      = 4'd0;
            cur_vstate     = VS_SKIP;
            cur_acc        = '0;
            cur_clv        = '0;
            cur_body_rem   = '0;
            cur_sticky     = hrf_pkg::ERR_NONE;
        end else begin
            cur_phase      = phase_reg;
            cur_space      = space_reg;
            cur_prev_cr    = prev_cr_reg;
            cur_line_empty = line_empty_reg;
            cur_colon      = colon_reg;
            cur_match      = match_reg;
            cur_vstate     = vstate_reg;
            cur_acc        = acc_reg;
            cur_clv        = clv_reg;
            cur_body_rem   = body_rem_reg;
            cur_sticky     = sticky_reg;
        end
    end

    // Decimal digit and acc*10 + digit, with the top four bits flagging overflow
    assign digit     = (b >= hrf_pkg::CHAR_ZERO) && (b <= hrf_pkg::CHAR_NINE);
    assign digit_val = b[3:0];
    assign acc_ext   = ExtBits'(cur_acc);
    assign acc_x10   = (acc_ext << 3) + (acc_ext << 1) + ExtBits'(digit_val);
    assign acc_ovf   = |acc_x10[ExtBits-1:LENGTH_BITS];
    assign clv_wide  = 64'(cur_clv);

    // Per-byte parser step
    always_comb begin
        phase_next      = cur_phase;
        space_next      = cur_space;
        prev_cr_next    = cur_prev_cr;
        line_empty_next = cur_line_empty;
        colon_next      = cur_colon;
        match_next      = cur_match;
        vstate_next     = cur_vstate;
        acc_next        = cur_acc;
        clv_next        = cur_clv;
        body_rem_next   = cur_body_rem;
        sticky_next     = cur_sticky;
        cls_next        = hrf_pkg::CLS_METHOD;
        hdr_end_next    = 1'b0;
        blen_next       = 32'd0;
        req_end_next    = 1'b0;
        err_next        = hrf_pkg::ERR_NONE;
        line_rst        = 1'b0;
        fail_code       = hrf_pkg::ERR_NONE;

        priority if (cur_sticky != hrf_pkg::ERR_NONE) begin
            fail_code = cur_sticky;
        end else if (cur_phase == PH_BODY) begin
            // body bytes pass unchecked, counted down to the request end
            cls_next      = hrf_pkg::CLS_BODY;
            body_rem_next = cur_body_rem - LENGTH_BITS'(1);
            if (cur_body_rem == LENGTH_BITS'(1)) begin
                req_end_next = 1'b1;
                phase_next   = PH_REQ;
                line_rst     = 1'b1;
            end
        end else if (!hrf_pkg::byte_ok(b)) begin
            fail_code = hrf_pkg::ERR_BAD_BYTE;
        end else if (b == hrf_pkg::CHAR_LF) begin
            // line end
            priority if (!cur_prev_cr) begin
                fail_code = hrf_pkg::ERR_BARE_LF;
            end else if (cur_phase == PH_REQ) begin
                if (cur_space != 2'd2) begin
                    fail_code = hrf_pkg::ERR_TOKENS;
                end else begin
                    cls_next   = hrf_pkg::CLS_SEP;
                    phase_next = PH_HDR;
                    line_rst   = 1'b1;
                end
            end else if (cur_line_empty) begin
                // blank line: header done
                cls_next     = hrf_pkg::CLS_SEP;
                hdr_end_next = 1'b1;
                blen_next    = clv_wide[31:0];
                if (cur_clv == '0) begin
                    req_end_next = 1'b1;
                    phase_next   = PH_REQ;
                end else begin
                    body_rem_next = cur_clv;
                    phase_next    = PH_BODY;
                end
                clv_next = '0;
                line_rst = 1'b1;
            end else if (!cur_colon) begin
                fail_code = hrf_pkg::ERR_NO_COLON;
            end else begin
                cls_next = hrf_pkg::CLS_SEP;
                if (cur_match == hrf_pkg::NAME_LEN) begin
                    clv_next = cur_acc;
                end
                line_rst = 1'b1;
            end
        end else begin
            // line content; a CR only counts once it is not followed by LF
            if (cur_prev_cr || (b != hrf_pkg::CHAR_CR)) begin
                line_empty_next = 1'b0;
            end
            prev_cr_next = (b == hrf_pkg::CHAR_CR);

            priority if (cur_phase == PH_REQ) begin
                priority if (b == hrf_pkg::CHAR_SPACE) begin
                    cls_next = hrf_pkg::CLS_SEP;
                    if (cur_space != 2'd3) begin
                        space_next = cur_space + 2'd1;
                    end
                end else if (b == hrf_pkg::CHAR_CR) begin
                    cls_next = hrf_pkg::CLS_SEP;
                end else if (cur_space == 2'd0) begin
                    cls_next = hrf_pkg::CLS_METHOD;
                end else if (cur_space == 2'd1) begin
                    cls_next = hrf_pkg::CLS_TARGET;
                end else begin
                    cls_next = hrf_pkg::CLS_VERSION;
                end
            end else if (!cur_colon) begin
                // header name, matched against the length key
                if (b == hrf_pkg::CHAR_COLON) begin
                    colon_next = 1'b1;
                    cls_next   = hrf_pkg::CLS_SEP;
                end else begin
                    cls_next = (b == hrf_pkg::CHAR_CR) ? hrf_pkg::CLS_SEP : hrf_pkg::CLS_NAME;
                    if (cur_match < hrf_pkg::NAME_LEN &&
                        hrf_pkg::to_lower(b) == hrf_pkg::key_char(cur_match)) begin
                        match_next = cur_match + 4'd1;
                    end else begin
                        match_next = hrf_pkg::NO_MATCH;
                    end
                end
            end else begin
                // header value; decimal parse for the length header
                cls_next = (b == hrf_pkg::CHAR_CR) ? hrf_pkg::CLS_SEP : hrf_pkg::CLS_VALUE;
                if (cur_match == hrf_pkg::NAME_LEN) begin
                    unique case (cur_vstate)
                        VS_SKIP: begin
                            if (digit) begin
                                acc_next    = LENGTH_BITS'(digit_val);
                                vstate_next = VS_DIGITS;
                            end else if (!hrf_pkg::is_ws(b)) begin
                                vstate_next = VS_DONE;
                            end
                        end
                        VS_DIGITS: begin
                            if (digit) begin
                                if (acc_ovf) begin
                                    fail_code = hrf_pkg::ERR_OVERFLOW;
                                end else begin
                                    acc_next = acc_x10[LENGTH_BITS-1:0];
                                end
                            end else begin
                                vstate_next = VS_DONE;
                            end
                        end
                        default: begin
                            vstate_next = cur_vstate;
                        end
                    endcase
                end
            end
        end

        if (line_rst) begin
            space_next      = 2'd0;
            prev_cr_next    = 1'b0;
            line_empty_next = 1'b1;
            colon_next      = 1'b0;
            match_next      = 4'd0;
            vstate_next     = VS_SKIP;
            acc_next        = '0;
        end

        // error result: only the code survives
        if (fail_code != hrf_pkg::ERR_NONE) begin
            sticky_next  = fail_code;
            cls_next     = hrf_pkg::CLS_METHOD;
            hdr_end_next = 1'b0;
            blen_next    = 32'd0;
            req_end_next = 1'b0;
            err_next     = fail_code;
        end
    end

    // State and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            phase_reg      <= PH_REQ;
            space_reg      <= 2'd0;
            prev_cr_reg    <= 1'b0;
            line_empty_reg <= 1'b1;
            colon_reg      <= 1'b0;
            match_reg      <= 4'd0;
            vstate_reg     <= VS_SKIP;
            acc_reg        <= '0;
            clv_reg        <= '0;
            body_rem_reg   <= '0;
            sticky_reg     <= hrf_pkg::ERR_NONE;
        end else begin
            if (accept) begin
                m_valid_reg    <= 1'b1;
                phase_reg      <= phase_next;
                space_reg      <= space_next;
                prev_cr_reg    <= prev_cr_next;
                line_empty_reg <= line_empty_next;
                colon_reg      <= colon_next;
                match_reg      <= match_next;
                vstate_reg     <= vstate_next;
                acc_reg        <= acc_next;
                clv_reg        <= clv_next;
                body_rem_reg   <= body_rem_next;
                sticky_reg     <= sticky_next;
                cls_reg        <= cls_next;
                hdr_end_reg    <= hdr_end_next;
                blen_reg       <= blen_next;
                req_end_reg    <= req_end_next;
                err_reg        <= err_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_byte_class  = cls_reg;
    assign m_header_end  = hdr_end_reg;
    assign m_body_length = blen_reg;
    assign m_request_end = req_end_reg;
    assign m_error_code  = err_reg;

    // Checks
    `HRF_ASSERT_SAME(a_hdr_end_is_sep, aclk, aresetn,
        m_valid && m_header_end,
        m_byte_class == hrf_pkg::CLS_SEP && m_error_code == hrf_pkg::ERR_NONE,
        "header end on a byte that is not a clean line break")
    `HRF_ASSERT_SAME(a_err_zeroes, aclk, aresetn,
        m_valid && m_error_code != hrf_pkg::ERR_NONE,
        m_byte_class == hrf_pkg::CLS_METHOD && !m_header_end && !m_request_end
            && m_body_length == 32'd0,
        "error item carries nonzero fields")
    `HRF_ASSERT_NEXT(a_err_sticky, aclk, aresetn,
        sticky_reg != hrf_pkg::ERR_NONE && !(accept && s_new_connection),
        sticky_reg == $past(sticky_reg),
        "sticky error changed without a new connection")
    `HRF_ASSERT_SAME(a_body_nonzero, aclk, aresetn,
        phase_reg == PH_BODY,
        body_rem_reg != '0,
        "body phase with no bytes left")

endmodule

/* tb/sv/request_frame_checker.sv */
// Watches both channels of the HTTP request framer, predicts the tag of every
// accepted byte and compares each result item with the oldest prediction.
module request_frame_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_new_connection,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_byte_class,
    input  logic        m_header_end,
    input  logic [31:0] m_body_length,
    input  logic        m_request_end,
    input  logic [2:0]  m_error_code,
    output int          pending,
    output int          mismatches
);

    typedef enum logic [1:0] {
        STAGE_REQ_LINE,
        STAGE_HEADERS,
        STAGE_BODY
    } stage_t;

    // Progress of a Content-Length value
    typedef enum logic [1:0] {
        NUM_IDLE,
        NUM_DIGITS,
        NUM_DONE
    } num_state_t;

    typedef struct packed {
        hrf_pkg::byte_class_t cls;
        logic                 hdr_end;
        logic [31:0]          len;
        logic                 req_end;
        hrf_pkg::err_t        err;
    } byte_tag_t;

    localparam bit [8*14-1:0] KEY_TEXT = "content-length";

    // Parser state as the predictor sees it
    stage_t        stage;
    logic [1:0]    spaces;
    logic          after_cr;
    logic          line_blank;
    logic          colon_hit;
    logic [3:0]    key_pos;
    num_state_t    num_state;
    logic [31:0]   len_acc;
    logic [31:0]   declared_len;
    logic [31:0]   body_left;
    hrf_pkg::err_t held_err;

    byte_tag_t     expected_tags[$];
    int            result_index;

    function automatic void restart_line();
        spaces     = 2'd0;
        after_cr   = 1'b0;
        line_blank = 1'b1;
        colon_hit  = 1'b0;
        key_pos    = 4'd0;
        num_state  = NUM_IDLE;
        len_acc    = '0;
    endfunction

    function automatic void clear_parser();
        stage = STAGE_REQ_LINE;
        restart_line();
        declared_len = '0;
        body_left    = '0;
        held_err     = hrf_pkg::ERR_NONE;
    endfunction

    // Latch an error; all other fields go to zero
    function automatic byte_tag_t raise(input hrf_pkg::err_t code);
        byte_tag_t t;
        held_err = code;
        t        = '0;
        t.err    = code;
        return t;
    endfunction

    function automatic byte_tag_t tag_byte(input logic [7:0] b, input logic fresh);
        byte_tag_t   t;
        logic        blank_char;
        logic        is_digit;
        logic [7:0]  lower;
        logic [35:0] grown;
        t = '0;
        if (fresh)
            clear_parser();
        if (held_err != hrf_pkg::ERR_NONE)
            return raise(held_err);

        // body bytes are counted, never inspected
        if (stage == STAGE_BODY) begin
            t.cls     = hrf_pkg::CLS_BODY;
            body_left = body_left - 32'd1;
            if (body_left == 0) begin
                t.req_end = 1'b1;
                stage     = STAGE_REQ_LINE;
                restart_line();
            end
            return t;
        end

        blank_char = (b == hrf_pkg::CHAR_SPACE) || (b >= 8'h09 && b <= 8'h0D);
        if (!(blank_char || (b >= 8'h20 && b < 8'h7F)))
            return raise(hrf_pkg::ERR_BAD_BYTE);

        // line break: close the current line
        if (b == hrf_pkg::CHAR_LF) begin
            if (!after_cr)
                return raise(hrf_pkg::ERR_BARE_LF);
            t.cls = hrf_pkg::CLS_SEP;
            if (stage == STAGE_REQ_LINE) begin
                if (spaces != 2'd2)
                    return raise(hrf_pkg::ERR_TOKENS);
                stage = STAGE_HEADERS;
            end else if (line_blank) begin
                t.hdr_end = 1'b1;
                t.len     = declared_len;
                if (declared_len == 0) begin
                    t.req_end = 1'b1;
                    stage     = STAGE_REQ_LINE;
                end else begin
                    body_left = declared_len;
                    stage     = STAGE_BODY;
                end
                declared_len = '0;
            end else begin
                if (!colon_hit)
                    return raise(hrf_pkg::ERR_NO_COLON);
                if (key_pos == hrf_pkg::NAME_LEN)
                    declared_len = len_acc;
            end
            restart_line();
            return t;
        end

        // a CR only counts as content once something follows it
        if (after_cr || b != hrf_pkg::CHAR_CR)
            line_blank = 1'b0;
        after_cr = (b == hrf_pkg::CHAR_CR);

        if (stage == STAGE_REQ_LINE) begin
            if (b == hrf_pkg::CHAR_SPACE) begin
                t.cls = hrf_pkg::CLS_SEP;
                if (spaces != 2'd3)
                    spaces++;
            end else if (b == hrf_pkg::CHAR_CR) begin
                t.cls = hrf_pkg::CLS_SEP;
            end else begin
                t.cls = (spaces == 2'd0) ? hrf_pkg::CLS_METHOD :
                        (spaces == 2'd1) ? hrf_pkg::CLS_TARGET : hrf_pkg::CLS_VERSION;
            end
        end else if (!colon_hit) begin
            if (b == hrf_pkg::CHAR_COLON) begin
                colon_hit = 1'b1;
                t.cls     = hrf_pkg::CLS_SEP;
            end else begin
                t.cls = (b == hrf_pkg::CHAR_CR) ? hrf_pkg::CLS_SEP : hrf_pkg::CLS_NAME;
                lower = (b >= 8'h41 && b <= 8'h5A) ? (b | 8'h20) : b;
                if (key_pos < hrf_pkg::NAME_LEN && lower == KEY_TEXT[8*(13-key_pos) +: 8])
                    key_pos++;
                else
                    key_pos = hrf_pkg::NO_MATCH;
            end
        end else begin
            t.cls = (b == hrf_pkg::CHAR_CR) ? hrf_pkg::CLS_SEP : hrf_pkg::CLS_VALUE;
            if (key_pos == hrf_pkg::NAME_LEN) begin
                is_digit = (b >= hrf_pkg::CHAR_ZERO && b <= hrf_pkg::CHAR_NINE);
                case (num_state)
                    NUM_IDLE: begin
                        if (is_digit) begin
                            len_acc   = {28'd0, b[3:0]};
                            num_state = NUM_DIGITS;
                        end else if (!blank_char) begin
                            num_state = NUM_DONE;
                        end
                    end
                    NUM_DIGITS: begin
                        if (is_digit) begin
                            grown = {4'd0, len_acc} * 36'd10 + {32'd0, b[3:0]};
                            if (grown[35:32] != 4'd0) begin
                                len_acc = '1;
                                return raise(hrf_pkg::ERR_OVERFLOW);
                            end
                            len_acc = grown[31:0];
                        end else begin
                            num_state = NUM_DONE;
                        end
                    end
                    default: ;
                endcase
            end
        end
        return t;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] item %0d: %s got %0h, expected %0h",
                 $realtime, result_index, what, got, want);
        mismatches++;
    endtask

    // Results are compared before new predictions are queued
    always @(posedge aclk) begin
        byte_tag_t want;
        if (!aresetn) begin
            clear_parser();
            expected_tags.delete();
            result_index = 0;
            pending <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_tags.size() == 0) begin
                    report_mismatch("result with nothing expected", 32'(m_byte_class),
                                    32'd0);
                end else begin
                    want = expected_tags.pop_front();
                    if (m_byte_class !== want.cls)
                        report_mismatch("byte_class", 32'(m_byte_class), 32'(want.cls));
                    if (m_header_end !== want.hdr_end)
                        report_mismatch("header_end", 32'(m_header_end),
                                        32'(want.hdr_end));
                    if (m_body_length !== want.len)
                        report_mismatch("body_length", m_body_length, want.len);
                    if (m_request_end !== want.req_end)
                        report_mismatch("request_end", 32'(m_request_end),
                                        32'(want.req_end));
                    if (m_error_code !== want.err)
                        report_mismatch("error_code", 32'(m_error_code), 32'(want.err));
                end
                result_index++;
            end
            if (s_valid && s_ready)
                expected_tags.push_back(tag_byte(s_data_byte, s_new_connection));
            pending <= expected_tags.size();
        end
    end

endmodule

/* tb/sv/testbench.sv */
module testbench;

    localparam int BYTE_GOAL = 1650;

    logic        aclk             = 1'b0;
    logic        aresetn          = 1'b0;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte      = 8'h00;
    logic        s_new_connection = 1'b0;
    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic [2:0]  m_byte_class;
    logic        m_header_end;
    logic [31:0] m_body_length;
    logic        m_request_end;
    logic [2:0]  m_error_code;

    int          pending;
    int          mismatches;
    int          sent_count = 0;
    bit          steady     = 1'b0;  // no idling on either side while set
    logic [7:0]  frame_bytes[$];

    always #5 aclk = ~aclk;

    http_request_framer_top u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_new_connection (s_new_connection),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_byte_class     (m_byte_class),
        .m_header_end     (m_header_end),
        .m_body_length    (m_body_length),
        .m_request_end    (m_request_end),
        .m_error_code     (m_error_code)
    );

    request_frame_checker u_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_new_connection (s_new_connection),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_byte_class     (m_byte_class),
        .m_header_end     (m_header_end),
        .m_body_length    (m_body_length),
        .m_request_end    (m_request_end),
        .m_error_code     (m_error_code),
        .pending          (pending),
        .mismatches       (mismatches)
    );

    // Hard stop in case the block hangs
    initial begin
        #3_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Receiver: random stall before each result item
    initial begin : result_drain
        int   stall;
        logic got;
        @(posedge aclk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 6);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do begin
                @(negedge aclk);
                got = m_valid;
                @(posedge aclk);
            end while (!got);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fresh);
        int   gap;
        logic taken;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_data_byte      <= b;
        s_new_connection <= fresh;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
        sent_count++;
    endtask

    // Ship the assembled bytes; the first one may open a new connection
    task automatic send_frame(input logic fresh);
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], fresh && (i == 0));
        frame_bytes.delete();
    endtask

    task automatic push_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            frame_bytes.push_back(txt[i]);
    endtask

    task automatic push_crlf();
        frame_bytes.push_back(hrf_pkg::CHAR_CR);
        frame_bytes.push_back(hrf_pkg::CHAR_LF);
    endtask

    function automatic logic [7:0] visible_char(input bit colon_ok);
        logic [7:0] c;
        c = 8'($urandom_range(33, 126));
        if (!colon_ok && c == hrf_pkg::CHAR_COLON)
            c = 8'h2D;
        return c;
    endfunction

    task automatic push_token(input int lo, input int hi, input bit colon_ok);
        repeat ($urandom_range(lo, hi))
            frame_bytes.push_back(visible_char(colon_ok));
    endtask

    // Leading part of the length header name, letters in random case
    task automatic push_key(input int upto);
        bit [8*14-1:0] key;
        logic [7:0]    c;
        key = "content-length";
        for (int i = 0; i < upto; i++) begin
            c = key[8*(13-i) +: 8];
            if (c >= 8'h61 && $urandom_range(0, 1) == 1)
                c = c - 8'd32;
            frame_bytes.push_back(c);
        end
    endtask

    // One request: request line, up to three headers, blank line, body.
    // Returns 1 when the stream should restart with a new connection.
    task automatic build_request(output bit restart);
        longint unsigned declared;
        int              v;
        int              pos;
        bit              is_len;
        restart  = 1'b0;
        declared = 0;

        push_token(1, 5, 1'b1);
        frame_bytes.push_back(hrf_pkg::CHAR_SPACE);
        push_token(1, 6, 1'b1);
        frame_bytes.push_back(hrf_pkg::CHAR_SPACE);
        push_token(1, 4, 1'b1);
        push_crlf();

        repeat ($urandom_range(0, 3)) begin
            is_len = 1'b0;
            case ($urandom_range(0, 3))
                0: push_token(1, 8, 1'b0);
                1: begin
                    // near miss of the length header
                    push_key($urandom_range(1, 14));
                    frame_bytes.push_back(visible_char(1'b0));
                end
                default: begin
                    push_key(14);
                    is_len = 1'b1;
                end
            endcase
            frame_bytes.push_back(hrf_pkg::CHAR_COLON);
            repeat ($urandom_range(0, 2))
                frame_bytes.push_back($urandom_range(0, 1) ? hrf_pkg::CHAR_SPACE : 8'h09);
            if (is_len) begin
                case ($urandom_range(0, 11))
                    0: begin
                        push_text("4294967295");
                        declared = 64'hFFFF_FFFF;
                    end
                    1: begin
                        push_text("4294967296");
                        restart = 1'b1;
                    end
                    2: begin
                        // eleven digits always overflow
                        frame_bytes.push_back(8'h39);
                        repeat (10) frame_bytes.push_back(8'($urandom_range(48, 57)));
                        restart = 1'b1;
                    end
                    3: begin
                        push_text("x7");
                        declared = 0;
                    end
                    4: begin
                        v = $urandom_range(0, 24);
                        push_text($sformatf("%0d ;q", v));
                        declared = 64'(v);
                    end
                    default: begin
                        v = $urandom_range(0, 24);
                        push_text($sformatf("%0d", v));
                        declared = 64'(v);
                    end
                endcase
            end else begin
                repeat ($urandom_range(0, 8))
                    frame_bytes.push_back($urandom_range(0, 4) == 0 ? hrf_pkg::CHAR_SPACE :
                                          visible_char(1'b1));
            end
            push_crlf();
        end
        push_crlf();

        // huge lengths: a few body bytes, then drop the connection
        if (declared > 40) begin
            repeat ($urandom_range(0, 6)) frame_bytes.push_back(8'($urandom_range(0, 255)));
            restart = 1'b1;
        end else begin
            repeat (int'(declared)) frame_bytes.push_back(8'($urandom_range(0, 255)));
        end

        // occasionally spoil the request
        if ($urandom_range(0, 7) == 0) begin
            pos = $urandom_range(0, frame_bytes.size() - 1);
            case ($urandom_range(0, 5))
                0: frame_bytes[pos] = 8'($urandom_range(0, 255));
                1: frame_bytes.delete(pos);
                2: frame_bytes.insert(pos, hrf_pkg::CHAR_LF);
                3: frame_bytes.insert(pos, hrf_pkg::CHAR_CR);
                4: frame_bytes.insert(1, hrf_pkg::CHAR_SPACE);
                default: begin
                    while (frame_bytes.size() > pos)
                        void'(frame_bytes.pop_back());
                end
            endcase
            restart = 1'b1;
        end
    endtask

    // One edge first, so the count includes an item taken at the current edge
    task automatic wait_drained();
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Stimulus and verdict
    initial begin : stimulus
        bit fresh_next;
        bit restart;
        int checkpoint;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // bad byte at both extremes; the error sticks
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'hFF);
        send_frame(1'b1);
        // LF without CR
        frame_bytes.push_back(hrf_pkg::CHAR_LF);
        send_frame(1'b1);
        // too many spaces saturate the count
        push_text("x    z");
        push_crlf();
        send_frame(1'b1);
        // header line without colon
        push_text("M / V");
        push_crlf();
        push_text("Ab");
        push_crlf();
        send_frame(1'b1);
        // shortest clean request
        push_text("G / 1");
        push_crlf();
        push_crlf();
        send_frame(1'b1);

        // hold off until every result is back
        s_valid <= 1'b0;
        wait_drained();

        fresh_next = 1'b1;
        checkpoint = sent_count + 400;
        while (sent_count < BYTE_GOAL) begin
            steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 11) == 0) begin
                // pure noise on a new connection
                repeat ($urandom_range(1, 10))
                    frame_bytes.push_back(8'($urandom_range(0, 255)));
                send_frame(1'b1);
                fresh_next = 1'b1;
            end else begin
                build_request(restart);
                send_frame(fresh_next || ($urandom_range(0, 9) == 0));
                fresh_next = restart;
            end
            if (sent_count >= checkpoint) begin
                s_valid <= 1'b0;
                wait_drained();
                checkpoint = sent_count + 400;
            end
        end

        s_valid <= 1'b0;
        steady  = 1'b0;
        wait_drained();
        repeat (4) @(posedge aclk);
        if (mismatches == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
